// ===== design/m3inv_pkg.sv =====
// Package for the 3x3 fixed-point matrix inverse.
// Holds widths, stage counts and the lane result type; no dependencies.
package m3inv_pkg;
    localparam int ElemW   = 16;
    localparam int MinorW  = 33;
    localparam int DetW    = 49;
    localparam int InvW    = 32;
    localparam int NumW    = MinorW + 24;   // adjugate scaled by 2^24
    localparam int QuotW   = NumW;          // quotient magnitude bound
    localparam int NumLanes = 9;
    localparam int InW     = NumLanes * ElemW;
    localparam int OutW    = NumLanes * InvW + 1 + DetW;
    localparam int OutBytesW = ((OutW + 7) / 8) * 8;
    // Divider stages: one quotient bit per stage.
    localparam int DivStages = QuotW;

    typedef logic signed [ElemW-1:0]  t_elem;
    typedef logic signed [MinorW-1:0] t_minor;
    typedef logic signed [DetW-1:0]   t_det;
    typedef logic signed [InvW-1:0]   t_inv;

    function automatic t_inv sat32(input logic signed [QuotW:0] q);
        t_inv res;
        if (q > $signed({{(QuotW-InvW+1){1'b0}}, {1'b0, {(InvW-1){1'b1}}}}))
            res = {1'b0, {(InvW-1){1'b1}}};
        else if (q < $signed({{(QuotW-InvW+1){1'b1}}, {1'b1, {(InvW-1){1'b0}}}}))
            res = {1'b1, {(InvW-1){1'b0}}};
        else
            res = q[InvW-1:0];
        return res;
    endfunction
endpackage

// ===== design/matrix3_inverse_adjugate.sv =====
// Top level of the 3x3 matrix inverse: front end, nine divider lanes, merge stage.
// Depends on m3inv_pkg, m3inv_front and m3inv_lane.
//
// Usage: one matrix beat on the slave stream, one result beat on the master stream.
// s_axis_tdata holds a00..a22, 16 bits each, a00 lowest. m_axis_tdata holds
// inv00..inv22 (32 bits each, inv00 lowest), then singular, then det_value.
// Throughput: one matrix per cycle while the output is not stalled. The path from the
// accepting edge to m_axis_tvalid runs through the front end's three stages (the first loads on the
// accepting edge), the lane input register, the 57-stage bit-per-stage dividers
// and the output register.
// The whole pipeline advances as one; when the receiver stalls with a result
// held in the output register, the pipeline freezes and s_axis_tready drops.
// Reset clears the valid bits of every stage; data registers are not reset.
// A zero determinant gives singular = 1 and zeros in every other field.
module matrix3_inverse_adjugate (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [m3inv_pkg::InW-1:0]        s_axis_tdata,  // a00..a22, 16b each
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [m3inv_pkg::OutBytesW-1:0]  m_axis_tdata   // inv00..inv22, singular, det_value
);
    import m3inv_pkg::*;

    // Front end (3), lane input register (1) and divider stages.
    localparam int Lat = 4 + DivStages;

    logic             n_en;
    logic [Lat-1:0]   r_vld;
    t_elem  [8:0]     n_a;
    t_minor [8:0]     w_adj;
    t_det             w_det;
    t_det             r_det [DivStages+1];
    t_inv   [8:0]     w_inv;
    logic             r_oval;
    logic [OutW-1:0]  r_out;

    assign n_en = !r_oval || m_axis_tready;
    assign s_axis_tready = n_en;
    assign n_a = s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_oval <= 1'b0;
        end else if (n_en) begin
            r_vld  <= {r_vld[Lat-2:0], s_axis_tvalid};
            r_oval <= r_vld[Lat-1];
        end
    end

    m3inv_front u_front (.i_clk(i_clk), .i_en(n_en), .i_a(n_a), .o_adj(w_adj), .o_det(w_det));

    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
        m3inv_lane u_lane (.i_clk(i_clk), .i_en(n_en), .i_adj(w_adj[l]), .i_det(w_det),
                           .o_inv(w_inv[l]));
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_det[0] <= w_det;
            for (int s = 0; s < DivStages; s++) r_det[s+1] <= r_det[s];
        end
    end

    // Merge: singular detection and output packing.
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            if (r_det[DivStages] == '0)
                r_out <= {{DetW{1'b0}}, 1'b1, {(NumLanes*InvW){1'b0}}};
            else
                r_out <= {r_det[DivStages], 1'b0, w_inv};
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = OutBytesW'(r_out);
endmodule

// ===== design/m3inv_front.sv =====
// Front end: 2x2 minors (adjugate) and exact determinant, three register stages.
// Depends on m3inv_pkg.
module m3inv_front (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  m3inv_pkg::t_elem [8:0]   i_a,
    output m3inv_pkg::t_minor [8:0]  o_adj,
    output m3inv_pkg::t_det          o_det
);
    import m3inv_pkg::*;

    logic signed [2*ElemW-1:0] r_p [18];
    t_minor r_adj [9];
    t_elem  r_a00, r_a01, r_a02;
    logic signed [DetW-1:0] r_t0, r_t1, r_t2;
    t_minor [8:0] r_adj2;

    // Operand index pairs of each minor p*q - r*s, in adjugate order.
    localparam int Ix [36] = '{4,8,5,7, 2,7,1,8, 1,5,2,4, 5,6,3,8, 0,8,2,6,
                               2,3,0,5, 3,7,4,6, 1,6,0,7, 0,4,1,3};

    // Stage 1: products.  Stage 2: minors.  Stage 3: determinant terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_p[2*k]   <= i_a[Ix[4*k]]   * i_a[Ix[4*k+1]];
                r_p[2*k+1] <= i_a[Ix[4*k+2]] * i_a[Ix[4*k+3]];
            end
        end
    end

    t_elem r_b0, r_b1, r_b2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b0 <= i_a[0]; r_b1 <= i_a[1]; r_b2 <= i_a[2];
            r_a00 <= r_b0; r_a01 <= r_b1; r_a02 <= r_b2;
            for (int k = 0; k < 9; k++)
                r_adj[k] <= MinorW'(r_p[2*k]) - MinorW'(r_p[2*k+1]);
            r_t0 <= DetW'(r_a00) * DetW'(r_adj[0]);
            r_t1 <= DetW'(r_a01) * DetW'(r_adj[3]);
            r_t2 <= DetW'(r_a02) * DetW'(r_adj[6]);
            for (int k = 0; k < 9; k++) r_adj2[k] <= r_adj[k];
        end
    end

    assign o_adj = r_adj2;
    assign o_det = r_t0 + r_t1 + r_t2;
endmodule

// ===== design/m3inv_lane.sv =====
// One divider lane: pipelined restoring divide of adj*2^24 by det, one bit per stage.
// Depends on m3inv_pkg.
module m3inv_lane (
    input  logic                i_clk,
    input  logic                i_en,
    input  m3inv_pkg::t_minor   i_adj,
    input  m3inv_pkg::t_det     i_det,
    output m3inv_pkg::t_inv     o_inv
);
    import m3inv_pkg::*;

    logic [NumW-1:0]  r_num [DivStages+1];
    logic [DetW-1:0]  r_den [DivStages+1];
    logic [DetW:0]    r_rem [DivStages+1];
    logic             r_neg [DivStages+1];

    logic [NumW-1:0] n_mag;
    logic [DetW-1:0] n_dmag;
    always_comb begin
        n_mag  = i_adj[MinorW-1] ? NumW'(-{i_adj, 24'd0}) : NumW'({i_adj, 24'd0});
        n_dmag = i_det[DetW-1] ? DetW'(-i_det) : DetW'(i_det);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= n_mag;
            r_den[0] <= n_dmag;
            r_rem[0] <= '0;
            r_neg[0] <= i_adj[MinorW-1] ^ i_det[DetW-1];
        end
    end

    for (genvar s = 0; s < DivStages; s++) begin : g_st
        logic [DetW:0] n_sh, n_df;
        always_comb begin
            n_sh = {r_rem[s][DetW-1:0], r_num[s][NumW-1]};
            n_df = n_sh - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                if (!n_df[DetW]) begin
                    r_rem[s+1] <= n_df;
                    r_num[s+1] <= {r_num[s][NumW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_sh;
                    r_num[s+1] <= {r_num[s][NumW-2:0], 1'b0};
                end
            end
        end
    end

    logic signed [QuotW:0] n_q;
    assign n_q = r_neg[DivStages] ? -$signed({1'b0, r_num[DivStages]})
                                  :  $signed({1'b0, r_num[DivStages]});
    assign o_inv = sat32(n_q);
endmodule

// ===== tb/matrix3_inverse_adjugate_tb.sv =====
// Self-checking testbench for matrix3_inverse_adjugate: drives 3x3 Q8.8 matrices
// and checks each inverse, singular flag and determinant against a local predictor.
// Depends on m3inv_pkg and the matrix3_inverse_adjugate RTL.
`timescale 1ns / 100ps

module matrix3_inverse_adjugate_tb;
    import m3inv_pkg::*;

    localparam int TimeoutCycles = 5000;
    localparam int LongHoldCycles = 400;
    localparam int RandItems = 540;

    typedef struct {
        t_elem a [9];
        int    gap;
        bit    drain;
    } t_matrix;

    typedef struct {
        t_inv inv [9];
        bit   singular;
        t_det det;
    } t_inverse;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InW-1:0]       s_axis_tdata;   // a00..a22, 16 bits each, a00 lowest
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutBytesW-1:0] m_axis_tdata;   // inv00..inv22, singular, det_value, zero pad

    t_matrix  pending_mats [$];
    t_inverse expected_inverses [$];
    bit       in_fire;
    bit       out_fire;
    bit       gap_loaded;
    int       gap_left;
    int       stall_left;
    bit       long_hold_done;
    int       results_seen;
    int       singular_seen;
    int       saturated_seen;
    int       mismatches;
    int       idle_cycles;

    matrix3_inverse_adjugate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint cofactor2(longint p, longint q, longint r, longint s);
        return p * q - r * s;
    endfunction

    // Exact adjugate and determinant, then adj * 2^24 / det truncated and saturated.
    function automatic t_inverse invert_matrix(t_elem a [9]);
        t_inverse res;
        longint   m [9];
        longint   adj [9];
        longint   det;
        longint   q;
        for (int i = 0; i < 9; i++) m[i] = a[i];
        adj[0] = cofactor2(m[4], m[8], m[5], m[7]);
        adj[1] = cofactor2(m[2], m[7], m[1], m[8]);
        adj[2] = cofactor2(m[1], m[5], m[2], m[4]);
        adj[3] = cofactor2(m[5], m[6], m[3], m[8]);
        adj[4] = cofactor2(m[0], m[8], m[2], m[6]);
        adj[5] = cofactor2(m[2], m[3], m[0], m[5]);
        adj[6] = cofactor2(m[3], m[7], m[4], m[6]);
        adj[7] = cofactor2(m[1], m[6], m[0], m[7]);
        adj[8] = cofactor2(m[0], m[4], m[1], m[3]);
        det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
        res.singular = (det == 0);
        res.det = res.singular ? '0 : t_det'(det);
        for (int i = 0; i < 9; i++) begin
            if (res.singular) begin
                res.inv[i] = '0;
            end else begin
                q = (adj[i] * 64'sd16777216) / det;
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                else if (q < -64'sd2147483648) q = -64'sd2147483648;
                res.inv[i] = t_inv'(q);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] result %0d: %s got %0d expected %0d", $realtime, results_seen,
                 field, got, want);
        mismatches++;
    endtask

    task automatic add_matrix(input int e [9], input bit drain = 0);
        t_matrix mt;
        for (int i = 0; i < 9; i++) mt.a[i] = t_elem'(e[i]);
        // Alternate runs of back-to-back beats with runs of random gaps.
        mt.gap = ((pending_mats.size() / 40) % 3 == 0) ? 0 : $urandom_range(0, 17);
        mt.drain = drain;
        pending_mats.push_back(mt);
    endtask

    // Monitor: sample both streams at the rising edge.
    always @(posedge i_clk) begin
        t_inverse got;
        t_inverse want;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire) begin
            t_matrix mt;
            for (int i = 0; i < 9; i++) mt.a[i] = s_axis_tdata[i*ElemW +: ElemW];
            expected_inverses.push_back(invert_matrix(mt.a));
        end
        if (out_fire) begin
            for (int i = 0; i < 9; i++) got.inv[i] = m_axis_tdata[i*InvW +: InvW];
            got.singular = m_axis_tdata[NumLanes*InvW];
            got.det = m_axis_tdata[NumLanes*InvW+1 +: DetW];
            if (expected_inverses.size() == 0) begin
                $display("[%0t] result beat with nothing expected", $realtime);
                mismatches++;
            end else begin
                want = expected_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.inv[i] !== want.inv[i])
                        report_mismatch($sformatf("inv%0d%0d", i / 3, i % 3),
                                        got.inv[i], want.inv[i]);
                if (got.singular !== want.singular)
                    report_mismatch("singular", got.singular, want.singular);
                if (got.det !== want.det)
                    report_mismatch("det_value", got.det, want.det);
                if (want.singular) singular_seen++;
                for (int i = 0; i < 9; i++)
                    if (want.inv[i] == 32'sh7fffffff || want.inv[i] == -32'sh80000000)
                        saturated_seen++;
            end
            results_seen++;
        end
        if (in_fire || out_fire || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= TimeoutCycles) begin
            $display("[%0t] no beat accepted for %0d cycles", $realtime, TimeoutCycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Driver: present the next matrix at the falling edge.
    always @(negedge i_clk) begin
        bit nv;
        nv = s_axis_tvalid && !in_fire;
        if (i_rst_n && !nv && pending_mats.size() > 0) begin
            if (!gap_loaded) begin
                gap_left = pending_mats[0].gap;
                gap_loaded = 1;
            end
            if (pending_mats[0].drain && expected_inverses.size() != 0) begin
                // Hold the item back until the pipeline has emptied.
            end else if (gap_left > 0) begin
                gap_left--;
            end else begin
                t_matrix mt;
                mt = pending_mats.pop_front();
                for (int i = 0; i < 9; i++) s_axis_tdata[i*ElemW +: ElemW] <= mt.a[i];
                nv = 1;
                gap_loaded = 0;
            end
        end
        s_axis_tvalid <= nv;
    end

    // Receiver: random stalls per result, one long hold-off that freezes the pipeline.
    always @(negedge i_clk) begin
        if (out_fire) begin
            if (results_seen == 80 && !long_hold_done) begin
                stall_left = LongHoldCycles;
                long_hold_done = 1;
            end else if ((results_seen / 50) % 3 == 1) begin
                stall_left = 0;
            end else begin
                stall_left = $urandom_range(0, 17);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    initial begin
        int e [9];
        int r;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        stall_left = 0;

        // Directed: identity, zero, extremes, singular and saturating cases.
        e = '{256, 0, 0, 0, 256, 0, 0, 0, 256};            add_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  add_matrix(e);
        e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        add_matrix(e);
        e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};   add_matrix(e);
        e = '{-32768, 32767, 0, 32767, -32768, 32767, 0, 32767, -32768};
        add_matrix(e);
        e = '{32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767};
        add_matrix(e);
        e = '{32767, 32766, 0, 32766, 32765, 0, 0, 0, 1};  add_matrix(e);
        e = '{32767, 32766, 0, 32766, 32765, 0, 0, 0, -1}; add_matrix(e);
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                  add_matrix(e);
        e = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};               add_matrix(e);
        e = '{0, 256, 0, 0, 0, 256, 256, 0, 0};            add_matrix(e);
        e = '{512, 128, -64, 0, 256, 32, -128, 16, 384};   add_matrix(e);
        e = '{1, 2, 3, 4, 5, 6, 7, 8, 9};                  add_matrix(e);
        e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};         add_matrix(e);
        e = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};      add_matrix(e);
        e = '{-32768, -32768, 0, 0, 1, 0, 0, 0, 1};        add_matrix(e);

        for (int n = 0; n < RandItems; n++) begin
            r = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++) begin
                if (r < 5) e[i] = $signed(16'($urandom));
                else if (r < 8) e[i] = $urandom_range(0, 1024) - 512;
                else e[i] = $urandom_range(0, 8) - 4;
            end
            // Some singular matrices with a repeated or scaled row.
            if (r == 4) for (int i = 0; i < 3; i++) e[6 + i] = e[3 + i];
            if (r == 7) for (int i = 0; i < 3; i++) e[i] = -e[3 + i];
            add_matrix(e, n == 300);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_mats.size() == 0 && !s_axis_tvalid && expected_inverses.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Checked %0d inverses: %0d singular, %0d saturated elements.",
                 results_seen, singular_seen, saturated_seen);
        $display("Included a %0d-cycle output hold-off and a full pipeline drain.",
                 LongHoldCycles);
        if (mismatches == 0 && expected_inverses.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/m3inv_pkg.sv
design/m3inv_front.sv
design/m3inv_lane.sv
design/matrix3_inverse_adjugate.sv
tb/matrix3_inverse_adjugate_tb.sv
